[sv/dcc_pkg.sv]
package dcc_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH = 32;
  localparam int MAX_BYTES   = 6;

  // One spare slot keeps the packet on the track apart from the pending ones.
  localparam int SLOTS      = QUEUE_DEPTH + 1;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int COUNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W      = $clog2(MAX_BYTES);
  localparam int STRIDE     = 1 << IDX_W;
  localparam int BYTE_DEPTH = SLOTS * STRIDE;
  localparam int BYTE_AW    = SLOT_W + IDX_W;
  localparam int LEN_W      = $clog2(MAX_BYTES + 1);
  localparam int FILL_W     = $clog2(MAX_BYTES + 2);
  localparam int DROP_MARK  = MAX_BYTES + 1;
  localparam int REP_W      = 2;
  localparam int RPT_W      = 3;
  localparam int META_W     = LEN_W + REP_W;

  // Bit position within a transmission
  localparam int POS_W    = 7;
  localparam int PRE_W    = 5;
  localparam int BI_W     = 4;
  localparam int RECIP    = 57;   // 57/512 approximates 1/9 exactly for positions below 128
  localparam int RECIP_SH = 9;
  localparam int PROD_W   = POS_W + 6;

  localparam int OVR_W     = 16;
  localparam int HALF_W    = 7;
  localparam int ONE_HALF  = 58;
  localparam int ZERO_HALF = 96;
  localparam int IDLE_LEN  = 3;

  // Ports
  localparam int S_DATA_W = 16;
  localparam int M_DATA_W = 32;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;
  localparam logic [PRE_W-1:0] PREAMBLE_RESET = PRE_W'(16);

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_BIT  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_COMMIT = 2'd1,
    ST_DROP   = 2'd2,
    ST_OFF    = 2'd3
  } push_status_t;

  typedef enum logic [1:0] {
    KIND_ONE  = 2'd0,
    KIND_ZERO = 2'd1,
    KIND_DATA = 2'd2,
    KIND_END  = 2'd3
  } bit_kind_t;

  typedef enum logic {
    REG_SIGNAL_ACTIVE  = 1'b0,
    REG_PREAMBLE_COUNT = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic             signal_active;
    logic [PRE_W-1:0] preamble_count;
  } cfg_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] byte_value;
    logic       last_byte;
    logic [1:0] repeat_request;
  } in_item_t;

  typedef struct packed {
    logic             bit_ok;
    bit_kind_t        kind;
    logic [2:0]       bb;
    logic [IDX_W-1:0] bi;
    logic             idle;
    push_status_t     status;
    logic [OVR_W-1:0] overrun;
  } s1_t;

  function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
    slot_next = (s == SLOT_W'(SLOTS - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

  function automatic logic [7:0] idle_byte(input logic [IDX_W-1:0] i);
    case (i)
      IDX_W'(0): idle_byte = 8'hFF;
      IDX_W'(1): idle_byte = 8'h00;
      IDX_W'(2): idle_byte = 8'hFF;
      default:   idle_byte = 8'h00;
    endcase
  endfunction

endpackage

[sv/dcc_ram.sv]
module dcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/dcc_cfg.sv]
module dcc_cfg
  import dcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_index_t idx;

  assign idx    = reg_index_t'(paddr[APB_AW-1:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.signal_active  <= 1'b0;
      cfg.preamble_count <= PREAMBLE_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_SIGNAL_ACTIVE:  cfg.signal_active  <= pwdata[0];
        REG_PREAMBLE_COUNT: cfg.preamble_count <= pwdata[PRE_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SIGNAL_ACTIVE:  prdata = APB_DW'(cfg.signal_active);
      REG_PREAMBLE_COUNT: prdata = APB_DW'(cfg.preamble_count);
    endcase
  end

endmodule

[sv/dcc_ctrl.sv]
module dcc_ctrl
  import dcc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               accept,
  input  in_item_t           item,
  output s1_t                s1_next,
  output logic               byte_we,
  output logic [BYTE_AW-1:0] byte_waddr,
  output logic [7:0]         byte_wdata,
  output logic               byte_re,
  output logic [BYTE_AW-1:0] byte_raddr,
  output logic               meta_we,
  output logic [SLOT_W-1:0]  meta_waddr,
  output logic [META_W-1:0]  meta_wdata,
  output logic               meta_re,
  output logic [SLOT_W-1:0]  meta_raddr,
  input  logic [META_W-1:0]  meta_rdata
);

  // Queue state
  logic [SLOT_W-1:0]  head, tail;
  logic [COUNT_W-1:0] count;
  logic [FILL_W-1:0]  fill;
  logic [OVR_W-1:0]   overrun;

  // Transmission state
  logic [SLOT_W-1:0] cur_slot;
  logic              cur_idle;
  logic [LEN_W-1:0]  cur_len;
  logic [POS_W-1:0]  bit_position;
  logic [RPT_W-1:0]  repeats_left;
  logic              fetch_pend;

  logic               is_push, is_bit;
  logic               room, commit, dropped;
  logic [FILL_W-1:0]  fill_inc;
  logic [OVR_W-1:0]   overrun_next;
  push_status_t       status;

  logic               fetch_now, take_queue, take_idle, idle_eff;
  logic [SLOT_W-1:0]  slot_eff;
  logic [LEN_W-1:0]   len_eff;
  logic [POS_W-1:0]   pre_ext, q, pay_bits, bb_full;
  logic [PROD_W-1:0]  prod;
  logic [BI_W-1:0]    bi_full;
  logic               lt_pre, past_end, sep_one;
  bit_kind_t          kind;

  assign is_push = accept && (item.op == OP_PUSH);
  assign is_bit  = accept && (item.op == OP_BIT) && cfg.signal_active;

  // Push side
  always_comb begin
    room     = (fill < FILL_W'(MAX_BYTES)) && (count < COUNT_W'(QUEUE_DEPTH));
    fill_inc = room ? fill + FILL_W'(1) : FILL_W'(DROP_MARK);
    dropped  = item.last_byte && (fill_inc == FILL_W'(DROP_MARK));
    commit   = item.last_byte && !dropped;

    overrun_next = overrun;
    status       = ST_OK;
    if (item.op == OP_PUSH) begin
      if (!cfg.signal_active) begin
        status = ST_OFF;
      end else if (dropped) begin
        status = ST_DROP;
        if (overrun != '1) begin
          overrun_next = overrun + OVR_W'(1);
        end
      end else if (commit) begin
        status = ST_COMMIT;
      end
    end
  end

  assign byte_we    = is_push && cfg.signal_active && room;
  assign byte_waddr = {tail, fill[IDX_W-1:0]};
  assign byte_wdata = item.byte_value;
  assign meta_we    = is_push && cfg.signal_active && commit;
  assign meta_waddr = tail;
  assign meta_wdata = {LEN_W'(fill_inc), item.repeat_request};

  // Bit side
  always_comb begin
    fetch_now  = (bit_position == '0);
    take_queue = fetch_now && (repeats_left == '0) && (count != '0);
    take_idle  = fetch_now && (repeats_left == '0) && (count == '0);
    slot_eff   = take_queue ? head : cur_slot;
    idle_eff   = take_queue ? 1'b0 : (take_idle ? 1'b1 : cur_idle);
    // Length just read from the queue lands in the cycle after the fetch
    len_eff    = fetch_pend ? meta_rdata[REP_W +: LEN_W] : cur_len;

    pre_ext  = POS_W'(cfg.preamble_count);
    q        = bit_position - pre_ext;
    prod     = PROD_W'(q) * PROD_W'(RECIP);
    bi_full  = prod[RECIP_SH +: BI_W];
    bb_full  = q - ((POS_W'(bi_full) << 3) + POS_W'(bi_full));
    pay_bits = (POS_W'(len_eff) << 3) + POS_W'(len_eff);
    sep_one  = (BI_W'(len_eff) == bi_full + BI_W'(1));

    lt_pre   = bit_position < pre_ext;
    // A fresh packet is never empty, so its first payload bit is always in range
    past_end = !fetch_now && !lt_pre && (q >= pay_bits);

    if (lt_pre) begin
      kind = KIND_ONE;
    end else if (past_end) begin
      kind = KIND_END;
    end else if (bb_full == POS_W'(8)) begin
      kind = sep_one ? KIND_ONE : KIND_ZERO;
    end else begin
      kind = KIND_DATA;
    end
  end

  assign byte_re    = is_bit;
  assign byte_raddr = {slot_eff, bi_full[IDX_W-1:0]};
  assign meta_re    = is_bit && take_queue;
  assign meta_raddr = head;

  always_comb begin
    s1_next.bit_ok  = (item.op == OP_BIT) && cfg.signal_active;
    s1_next.kind    = kind;
    s1_next.bb      = bb_full[2:0];
    s1_next.bi      = bi_full[IDX_W-1:0];
    s1_next.idle    = idle_eff;
    s1_next.status  = status;
    s1_next.overrun = overrun_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head         <= '0;
      tail         <= '0;
      count        <= '0;
      fill         <= '0;
      overrun      <= '0;
      cur_slot     <= '0;
      cur_idle     <= 1'b1;
      cur_len      <= '0;
      bit_position <= '0;
      repeats_left <= '0;
      fetch_pend   <= 1'b0;
    end else begin
      fetch_pend <= is_bit && take_queue;
      if (fetch_pend) begin
        cur_len      <= meta_rdata[REP_W +: LEN_W];
        repeats_left <= RPT_W'(meta_rdata[REP_W-1:0]) + RPT_W'(1);
      end

      if (is_push) begin
        overrun <= overrun_next;
        if (!cfg.signal_active) begin
          fill <= '0;
        end else if (item.last_byte) begin
          fill <= '0;
          if (commit) begin
            tail  <= slot_next(tail);
            count <= count + COUNT_W'(1);
          end
        end else begin
          fill <= fill_inc;
        end
      end

      if (is_bit) begin
        if (fetch_now) begin
          if (repeats_left != '0) begin
            repeats_left <= repeats_left - RPT_W'(1);
          end else if (take_queue) begin
            cur_slot <= head;
            cur_idle <= 1'b0;
            head     <= slot_next(head);
            count    <= count - COUNT_W'(1);
          end else begin
            cur_idle     <= 1'b1;
            cur_len      <= LEN_W'(IDLE_LEN);
            repeats_left <= RPT_W'(1);
          end
        end
        bit_position <= past_end ? '0 : bit_position + POS_W'(1);
      end
    end
  end

endmodule

[sv/dcc_packet_bit_encoder.sv]
// Channel   Dir  Handshake         Payload
// s_*       in   s_tvalid/s_tready tdata: byte_value, repeat_request; tuser: operation;
//                                  tlast: last_byte
// m_*       out  m_tvalid/m_tready tdata: bit_value, half_period_us, bit_valid, push_status,
//                                  overrun_total; tlast: packet_end
// apb       in   psel/penable      two registers, signal_active at 0x0, preamble_count at 0x4
//
// One item per cycle while s_tready is high; a result passes the memory read stage, then the
// output register. The queue memories are read at the transfer edge, one byte a bit.
// Reset is synchronous; queue memories are not cleared.
// While the output register is held, one more item enters, then s_tready drops.
module dcc_packet_bit_encoder
  import dcc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // [7:0] byte_value, [9:8] repeat_request
  input  logic                s_tuser,   // [0] operation
  input  logic                s_tlast,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,   // [0] bit_value, [7:1] half_period_us,
                                         // [8] bit_valid, [10:9] push_status,
                                         // [26:11] overrun_total
  output logic                m_tlast,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready
);

  cfg_t     cfg;
  in_item_t item;
  s1_t      s1_next, s1;
  logic     s1_valid, advance, accept;

  logic               byte_we, byte_re, meta_we, meta_re;
  logic [BYTE_AW-1:0] byte_waddr, byte_raddr;
  logic [7:0]         byte_wdata, byte_rdata;
  logic [SLOT_W-1:0]  meta_waddr, meta_raddr;
  logic [META_W-1:0]  meta_wdata, meta_rdata;

  logic [7:0]        sel_byte;
  logic              data_bit, out_bit, out_end;
  logic [HALF_W-1:0] half;

  dcc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign item.op             = op_t'(s_tuser);
  assign item.byte_value     = s_tdata[7:0];
  assign item.last_byte      = s_tlast;
  assign item.repeat_request = s_tdata[9:8];

  assign advance  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || advance;
  assign accept   = s_tvalid && s_tready;

  dcc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .accept     (accept),
    .item       (item),
    .s1_next    (s1_next),
    .byte_we    (byte_we),
    .byte_waddr (byte_waddr),
    .byte_wdata (byte_wdata),
    .byte_re    (byte_re),
    .byte_raddr (byte_raddr),
    .meta_we    (meta_we),
    .meta_waddr (meta_waddr),
    .meta_wdata (meta_wdata),
    .meta_re    (meta_re),
    .meta_raddr (meta_raddr),
    .meta_rdata (meta_rdata)
  );

  dcc_ram #(.WIDTH(8), .DEPTH(BYTE_DEPTH)) u_byte_ram (
    .clk   (clk),
    .we    (byte_we),
    .waddr (byte_waddr),
    .wdata (byte_wdata),
    .re    (byte_re),
    .raddr (byte_raddr),
    .rdata (byte_rdata)
  );

  dcc_ram #(.WIDTH(META_W), .DEPTH(SLOTS)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .re    (meta_re),
    .raddr (meta_raddr),
    .rdata (meta_rdata)
  );

  // Pick the payload bit from the byte read for this transfer
  always_comb begin
    sel_byte = s1.idle ? idle_byte(s1.bi) : byte_rdata;
    data_bit = sel_byte[3'd7 - s1.bb];
    case (s1.kind)
      KIND_ONE:  out_bit = 1'b1;
      KIND_ZERO: out_bit = 1'b0;
      KIND_DATA: out_bit = data_bit;
      default:   out_bit = 1'b1;
    endcase
    if (!s1.bit_ok) begin
      out_bit = 1'b0;
    end
    out_end = s1.bit_ok && (s1.kind == KIND_END);
    if (!s1.bit_ok) begin
      half = '0;
    end else begin
      half = out_bit ? HALF_W'(ONE_HALF) : HALF_W'(ZERO_HALF);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= s1_next;
    end
    if (advance) begin
      m_tdata <= M_DATA_W'({s1.overrun, s1.status, s1.bit_ok, half, out_bit});
      m_tlast <= out_end;
    end
  end

endmodule

[sv/dcc_checker.sv]
module dcc_checker
  import dcc_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata,
  input logic                m_tlast
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // Half-period must follow the bit, and be zero when no bit is given
  a_half: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[8] ?
      (m_tdata[7:1] == (m_tdata[0] ? HALF_W'(ONE_HALF) : HALF_W'(ZERO_HALF))) :
      (m_tdata[7:0] == 8'h00)))
    else $error("half period does not match bit");

  a_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[8] && m_tdata[0])
    else $error("packet end on a non-one bit");

  // A push result never carries a track bit
  a_push: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[10:9] != ST_OK) |-> !m_tdata[8])
    else $error("push status together with a bit");

endmodule

bind dcc_packet_bit_encoder dcc_checker u_dcc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
